// ===== rtl/fbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants for the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int NUM_BLOCKS = 4096;
    localparam int IDX_W      = 12;
    localparam int CNT_W      = 13;
    localparam int LINK_DEPTH = 2 ** IDX_W;
    localparam int POOL_SIZE  = (NUM_BLOCKS > LINK_DEPTH) ? LINK_DEPTH : NUM_BLOCKS;

    localparam logic [CNT_W-1:0] POOL_LIMIT     = CNT_W'(POOL_SIZE);
    localparam logic [CNT_W:0]   POOL_LIMIT_EXT = (CNT_W + 1)'(POOL_SIZE);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_OOM   = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    typedef struct packed {
        logic             opcode;
        logic [IDX_W-1:0] block_index;
        logic [CNT_W-1:0] block_count;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] granted_index;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_FREE,
        ST_RESP
    } state_t;

endpackage

// ===== rtl/fixed_block_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Fixed-size block allocator: LIFO free list in a link RAM plus a frontier.
// ----------------------------------------------------------------------------
// Sequencing: an allocation from the free list reads the link RAM in ST_READ and
//   stages the result from there; an allocation from the frontier or out of
//   memory, an empty free or a bad run goes through ST_RESP; a free of N blocks
//   writes them in ST_FREE, then goes through ST_RESP. One transaction at a time;
//   the next is accepted once the result is staged; free writes one block per cycle.
// Reset: list empty, head and frontier zero; link RAM is not cleared.
module fixed_block_pool_allocator (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  fbpa_pkg::req_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output fbpa_pkg::rsp_t out_data
);

    logic                       wr_en;
    logic [fbpa_pkg::IDX_W-1:0] wr_addr;
    logic [fbpa_pkg::IDX_W-1:0] wr_data;
    logic                       rd_en;
    logic [fbpa_pkg::IDX_W-1:0] rd_addr;
    logic [fbpa_pkg::IDX_W-1:0] rd_data;

    fbpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    fbpa_link_ram #(
        .DATA_W (fbpa_pkg::IDX_W),
        .ADDR_W (fbpa_pkg::IDX_W)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

// ===== rtl/fbpa_link_ram.sv =====
// ----------------------------------------------------------------------------
// fbpa_link_ram
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module fbpa_link_ram #(
    parameter int DATA_W = 12,
    parameter int ADDR_W = 12
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/fbpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Free list sequencer: head, frontier, run pushes and the output register.
// ----------------------------------------------------------------------------
module fbpa_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  fbpa_pkg::req_t              in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output fbpa_pkg::rsp_t              out_data,
    output logic                        wr_en,
    output logic [fbpa_pkg::IDX_W-1:0]  wr_addr,
    output logic [fbpa_pkg::IDX_W-1:0]  wr_data,
    output logic                        rd_en,
    output logic [fbpa_pkg::IDX_W-1:0]  rd_addr,
    input  logic [fbpa_pkg::IDX_W-1:0]  rd_data
);

    fbpa_pkg::state_t                state_reg, state_next;
    logic [fbpa_pkg::IDX_W-1:0]      head_reg, head_next;
    logic                            empty_reg, empty_next;
    logic [fbpa_pkg::CNT_W-1:0]      frontier_reg, frontier_next;
    logic [fbpa_pkg::IDX_W-1:0]      cur_reg, cur_next;
    logic [fbpa_pkg::CNT_W-1:0]      rem_reg, rem_next;
    fbpa_pkg::rsp_t                  pend_reg, pend_next;
    logic                            out_valid_reg, out_valid_next;
    fbpa_pkg::rsp_t                  out_reg, out_next;
    logic                            slot_free;
    logic [fbpa_pkg::CNT_W:0]        run_end;

    assign slot_free = !out_valid_reg || out_ready;
    assign run_end   = {2'b00, in_data.block_index} + {1'b0, in_data.block_count};

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        empty_next     = empty_reg;
        frontier_next  = frontier_reg;
        cur_next       = cur_reg;
        rem_next       = rem_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        in_ready       = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = head_reg;
        wr_en          = 1'b0;
        wr_addr        = cur_reg;
        wr_data        = empty_reg ? cur_reg : head_reg;

        case (state_reg)
            fbpa_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_data.opcode == fbpa_pkg::OP_ALLOC)
                    begin
                        if (!empty_reg)
                        begin
                            rd_en      = 1'b1;
                            state_next = fbpa_pkg::ST_READ;
                        end
                        else if (frontier_reg < fbpa_pkg::POOL_LIMIT)
                        begin
                            pend_next.status        = fbpa_pkg::STATUS_OK;
                            pend_next.granted_index = frontier_reg[fbpa_pkg::IDX_W-1:0];
                            frontier_next           = frontier_reg + 1'b1;
                            state_next              = fbpa_pkg::ST_RESP;
                        end
                        else
                        begin
                            pend_next.status        = fbpa_pkg::STATUS_OOM;
                            pend_next.granted_index = '0;
                            state_next              = fbpa_pkg::ST_RESP;
                        end
                    end
                    else if (run_end > fbpa_pkg::POOL_LIMIT_EXT)
                    begin
                        pend_next.status        = fbpa_pkg::STATUS_RANGE;
                        pend_next.granted_index = '0;
                        state_next              = fbpa_pkg::ST_RESP;
                    end
                    else if (in_data.block_count == '0)
                    begin
                        pend_next.status        = fbpa_pkg::STATUS_OK;
                        pend_next.granted_index = '0;
                        state_next              = fbpa_pkg::ST_RESP;
                    end
                    else
                    begin
                        cur_next   = in_data.block_index;
                        rem_next   = in_data.block_count;
                        state_next = fbpa_pkg::ST_FREE;
                    end
                end
            end

            fbpa_pkg::ST_READ:
            begin
                if (slot_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.status        = fbpa_pkg::STATUS_OK;
                    out_next.granted_index = head_reg;
                    if (rd_data == head_reg)
                    begin
                        empty_next = 1'b1;
                    end
                    else
                    begin
                        head_next = rd_data;
                    end
                    state_next = fbpa_pkg::ST_IDLE;
                end
            end

            fbpa_pkg::ST_FREE:
            begin
                // push one block of the run per cycle
                wr_en      = 1'b1;
                head_next  = cur_reg;
                empty_next = 1'b0;
                cur_next   = cur_reg + 1'b1;
                rem_next   = rem_reg - 1'b1;
                if (rem_reg == fbpa_pkg::CNT_W'(1))
                begin
                    pend_next.status        = fbpa_pkg::STATUS_OK;
                    pend_next.granted_index = '0;
                    state_next              = fbpa_pkg::ST_RESP;
                end
            end

            fbpa_pkg::ST_RESP:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = pend_reg;
                    state_next     = fbpa_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = fbpa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fbpa_pkg::ST_IDLE;
            head_reg      <= '0;
            empty_reg     <= 1'b1;
            frontier_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            empty_reg     <= empty_next;
            frontier_reg  <= frontier_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        rem_reg  <= rem_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/fbpa_checker.sv =====
// ----------------------------------------------------------------------------
// fbpa_checker
// Port-level checks for the fixed block pool allocator.
// ----------------------------------------------------------------------------
module fbpa_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input fbpa_pkg::req_t in_data,
    input logic           out_valid,
    input logic           out_ready,
    input fbpa_pkg::rsp_t out_data
);

    a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != fbpa_pkg::STATUS_OK) |->
            (out_data.granted_index == '0))
        else $error("granted index nonzero on failed transaction");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction accepted while busy");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed or dropped");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== tb/fixed_block_pool_allocator_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_test
// Drives allocate and free transactions into the pool allocator and checks
// every response against a cycle-free model of the free list and frontier.
// A directed sequence comes first, then random traffic under several idle
// patterns, with one pass that empties the list and allocates from the frontier.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_test;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_WAIT   = 10;
    localparam int FRESH_ALLOCS = 24;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    fbpa_pkg::req_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    fbpa_pkg::rsp_t out_data;

    fbpa_pkg::req_t pending_reqs[$];
    fbpa_pkg::rsp_t expected_rsp[$];
    fbpa_pkg::rsp_t head_rsp;
    logic in_taken = 1'b0;

    int unsigned queued_count   = 0;
    int unsigned accepted_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned mismatch_count = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    logic [fbpa_pkg::IDX_W-1:0] link_ram [fbpa_pkg::LINK_DEPTH];
    logic [fbpa_pkg::IDX_W-1:0] list_head  = '0;
    logic                       list_empty = 1'b1;
    logic [fbpa_pkg::CNT_W-1:0] next_fresh = '0;

    fixed_block_pool_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic fbpa_pkg::rsp_t predict_response(fbpa_pkg::req_t req);
        fbpa_pkg::rsp_t             rsp;
        logic [fbpa_pkg::IDX_W-1:0] nxt;
        logic [fbpa_pkg::IDX_W-1:0] blk;
        int unsigned                first;
        int unsigned                span;
        int unsigned                k;
        rsp.status        = fbpa_pkg::STATUS_OK;
        rsp.granted_index = '0;
        if (req.opcode == fbpa_pkg::OP_ALLOC)
        begin
            if (!list_empty)
            begin
                nxt               = link_ram[list_head];
                rsp.granted_index = list_head;
                if (nxt == list_head)
                    list_empty = 1'b1;
                else
                    list_head = nxt;
            end
            else if (next_fresh < fbpa_pkg::POOL_SIZE)
            begin
                rsp.granted_index = next_fresh[fbpa_pkg::IDX_W-1:0];
                next_fresh        = next_fresh + 1'b1;
            end
            else
                rsp.status = fbpa_pkg::STATUS_OOM;
        end
        else
        begin
            first = req.block_index;
            span  = req.block_count;
            if (first + span > fbpa_pkg::POOL_SIZE)
                rsp.status = fbpa_pkg::STATUS_RANGE;
            else
                for (k = 0; k < span; k++)
                begin
                    blk           = fbpa_pkg::IDX_W'(first + k);
                    link_ram[blk] = list_empty ? blk : list_head;
                    list_head     = blk;
                    list_empty    = 1'b0;
                end
        end
        return rsp;
    endfunction

    task automatic queue_request(input logic op, input int unsigned base,
                                 input int unsigned count);
        fbpa_pkg::req_t req;
        req.opcode      = op;
        req.block_index = fbpa_pkg::IDX_W'(base);
        req.block_count = fbpa_pkg::CNT_W'(count);
        pending_reqs.push_back(req);
        queued_count++;
    endtask

    task automatic queue_random(input int n);
        int unsigned sel;
        int unsigned base;
        int unsigned count;
        repeat (n)
        begin
            sel = $urandom_range(99);
            if (sel < 50)
                queue_request(fbpa_pkg::OP_ALLOC, $urandom, $urandom);
            else if (sel < 78)
            begin
                count = $urandom_range(1, 8);
                queue_request(fbpa_pkg::OP_FREE, $urandom_range(255), count);
            end
            else if (sel < 83)
                queue_request(fbpa_pkg::OP_FREE, $urandom, 0);
            else if (sel < 89)
            begin
                base  = $urandom_range(fbpa_pkg::LINK_DEPTH - 1);
                count = $urandom_range(fbpa_pkg::POOL_SIZE - base + 1,
                                       2 ** fbpa_pkg::CNT_W - 1);
                queue_request(fbpa_pkg::OP_FREE, base, count);
            end
            else if (sel < 96)
            begin
                count = $urandom_range(1, 8);
                queue_request(fbpa_pkg::OP_FREE,
                              fbpa_pkg::POOL_SIZE - count - $urandom_range(3), count);
            end
            else
            begin
                count = $urandom_range(9, 64);
                queue_request(fbpa_pkg::OP_FREE,
                              $urandom_range(fbpa_pkg::POOL_SIZE - count), count);
            end
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (accepted_count != queued_count || expected_rsp.size() != 0);
        @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_data  <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("fixed_block_pool_allocator_test failed");
                $finish;
            end
            else
            begin
                if (out_valid && out_ready)
                begin
                    if (expected_rsp.size() == 0)
                    begin
                        $error("response with no transaction outstanding: status %0d index %0d",
                               out_data.status, out_data.granted_index);
                        mismatch_count++;
                    end
                    else
                    begin
                        head_rsp = expected_rsp.pop_front();
                        if (out_data.status !== head_rsp.status)
                        begin
                            $error("status: expected %0d, actual %0d",
                                   head_rsp.status, out_data.status);
                            mismatch_count++;
                        end
                        if (out_data.granted_index !== head_rsp.granted_index)
                        begin
                            $error("granted_index: expected %0d, actual %0d",
                                   head_rsp.granted_index, out_data.granted_index);
                            mismatch_count++;
                        end
                    end
                end
                if (in_valid && in_ready)
                begin
                    expected_rsp.push_back(predict_response(in_data));
                    accepted_count++;
                end
                in_taken <= in_valid && in_ready;
            end
        end
    end

    initial
    begin
        int fresh_left;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_request(fbpa_pkg::OP_ALLOC, 0, 0);
        queue_request(fbpa_pkg::OP_ALLOC, 4095, 8191);
        queue_request(fbpa_pkg::OP_ALLOC, 0, 0);
        queue_request(fbpa_pkg::OP_FREE, 0, 0);
        queue_request(fbpa_pkg::OP_FREE, 4095, 0);
        queue_request(fbpa_pkg::OP_FREE, 4095, 1);
        queue_request(fbpa_pkg::OP_FREE, 4095, 2);
        queue_request(fbpa_pkg::OP_FREE, 0, 4097);
        queue_request(fbpa_pkg::OP_FREE, 1, 4096);
        queue_request(fbpa_pkg::OP_FREE, 4095, 8191);
        queue_request(fbpa_pkg::OP_FREE, 1, 2);
        queue_request(fbpa_pkg::OP_FREE, 2, 1);
        queue_request(fbpa_pkg::OP_ALLOC, 0, 0);
        queue_request(fbpa_pkg::OP_ALLOC, 0, 0);
        queue_request(fbpa_pkg::OP_FREE, 0, 3);
        repeat (4) queue_request(fbpa_pkg::OP_ALLOC, 0, 0);
        queue_request(fbpa_pkg::OP_FREE, 4094, 2);
        queue_request(fbpa_pkg::OP_ALLOC, 0, 0);
        queue_request(fbpa_pkg::OP_ALLOC, 0, 0);
        queue_request(fbpa_pkg::OP_FREE, 0, 4096);
        queue_request(fbpa_pkg::OP_ALLOC, 0, 0);
        wait_idle();

        queue_random(225);
        wait_idle();

        send_idle_pct = 67;
        queue_random(225);
        wait_idle();

        // collapse the list to its head, pop it, then allocate from the frontier
        send_idle_pct  = 0;
        recv_stall_pct = 67;
        if (!list_empty)
        begin
            queue_request(fbpa_pkg::OP_FREE, list_head, 1);
            queue_request(fbpa_pkg::OP_ALLOC, 0, 0);
        end
        fresh_left = fbpa_pkg::POOL_SIZE - int'(next_fresh);
        if (fresh_left > FRESH_ALLOCS)
            fresh_left = FRESH_ALLOCS;
        repeat (fresh_left + 2) queue_request(fbpa_pkg::OP_ALLOC, $urandom, $urandom);
        wait_idle();

        queue_random(225);
        wait_idle();

        send_idle_pct  = 11;
        recv_stall_pct = 11;
        queue_random(225);
        wait_idle();

        repeat (DRAIN_WAIT) @(negedge clk);
        if (mismatch_count == 0 && expected_rsp.size() == 0)
            $display("fixed_block_pool_allocator_test passed");
        else
            $display("fixed_block_pool_allocator_test failed");
        $finish;
    end

endmodule
